### hw/rtl/three_body_gravity_accel_defines.svh
// ----------------------------------------------------------------------------
// three_body_gravity_accel_defines
// assertion macros shared by the gravity acceleration block
// ----------------------------------------------------------------------------
`ifndef THREE_BODY_GRAVITY_ACCEL_DEFINES_SVH
`define THREE_BODY_GRAVITY_ACCEL_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TBGA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbga assertion failed");

// next-cycle implication
`define TBGA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbga assertion failed");

`else

`define TBGA_ASSERT_NOW(label, ante, cons)
`define TBGA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hw/rtl/tbga_pkg.sv
// ----------------------------------------------------------------------------
// tbga_pkg
// widths, pipeline depths and word types of the gravity acceleration block
// ----------------------------------------------------------------------------
`default_nettype none

package tbga_pkg;

    localparam int NUM_AXES     = 3;
    localparam int POS_W        = 32;
    localparam int DIFF_W       = POS_W + 1;
    localparam int MAG_W        = POS_W;
    localparam int MASS_W       = 31;
    localparam int CFG_W        = 32;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int ROOT_W       = 33;
    localparam int TRIAL_W      = SUM_W + 2;
    localparam int SPLIT_W      = SUM_W / 2;
    localparam int PART_W       = SPLIT_W + ROOT_W;
    localparam int DEN_W        = SUM_W + ROOT_W;
    localparam int PROD_W       = MASS_W + MAG_W;
    localparam int FRAC_SHIFT   = 48;
    localparam int NUM_W        = PROD_W + FRAC_SHIFT;
    localparam int QUOT_W       = 41;
    localparam int TERM_W       = QUOT_W + 1;
    localparam int ACC_SUM_W    = TERM_W + 1;
    localparam int ACC_W        = 32;

    localparam int FRONT_STAGES = 3;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DEN_STAGES   = 2;
    localparam int DIV_STAGES   = QUOT_W;
    localparam int PAIR_LAT     = FRONT_STAGES + SQRT_STAGES + DEN_STAGES + DIV_STAGES;
    localparam int PROD_DLY     = 1 + SQRT_STAGES + DEN_STAGES;
    localparam int FLAG_DLY     = SQRT_STAGES + DEN_STAGES + DIV_STAGES;

    localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(65536);

    localparam logic signed [ACC_SUM_W-1:0] ACC_MAX =
        {{(ACC_SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_SUM_W-1:0] ACC_MIN =
        {{(ACC_SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [POS_W-1:0] pos0_x;
        logic signed [POS_W-1:0] pos0_y;
        logic signed [POS_W-1:0] pos0_z;
        logic signed [POS_W-1:0] pos1_x;
        logic signed [POS_W-1:0] pos1_y;
        logic signed [POS_W-1:0] pos1_z;
        logic signed [POS_W-1:0] pos2_x;
        logic signed [POS_W-1:0] pos2_y;
        logic signed [POS_W-1:0] pos2_z;
    } pos_word_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc0_x;
        logic signed [ACC_W-1:0] acc0_y;
        logic signed [ACC_W-1:0] acc0_z;
        logic signed [ACC_W-1:0] acc1_x;
        logic signed [ACC_W-1:0] acc1_y;
        logic signed [ACC_W-1:0] acc1_z;
        logic signed [ACC_W-1:0] acc2_x;
        logic signed [ACC_W-1:0] acc2_y;
        logic signed [ACC_W-1:0] acc2_z;
        logic                    coincident_pair;
        logic                    accel_saturated;
    } acc_word_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][QUOT_W-1:0] quot;
        logic [NUM_AXES-1:0]             neg;
        logic                            coin;
    } pair_res_t;

endpackage

`default_nettype wire

### hw/rtl/three_body_gravity_accel.sv
// each result word runs through the pair pipes, then the output register
// throughput: one word per cycle when not stalled; the depth is set by the
// 33-stage square root and the 41-stage dividers, all advancing together
// a held result stalls the whole pipeline, nothing is dropped
// reset clears the valid bits and sets mass_reg to 1.0
// ----------------------------------------------------------------------------
// three_body_gravity_accel
// gravitational acceleration of three equal-mass bodies, fixed point
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_body_gravity_accel_defines.svh"

module three_body_gravity_accel (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pos_valid,
    output logic                             pos_ready,
    input  wire tbga_pkg::pos_word_t         pos,
    output logic                             acc_valid,
    input  wire logic                        acc_ready,
    output tbga_pkg::acc_word_t              acc,
    input  wire logic                        cfg_we,
    input  wire logic [tbga_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int NA  = tbga_pkg::NUM_AXES;
    localparam int PL  = tbga_pkg::PAIR_LAT;
    localparam int TW  = tbga_pkg::TERM_W;
    localparam int ASW = tbga_pkg::ACC_SUM_W;
    localparam int AW  = tbga_pkg::ACC_W;
    localparam int PW  = tbga_pkg::POS_W;
    localparam int MSW = tbga_pkg::MASS_W;

    logic [MSW-1:0]  mass_reg;
    logic [PL-1:0]   vld_reg;
    logic            acc_valid_reg;
    tbga_pkg::acc_word_t acc_reg;
    tbga_pkg::acc_word_t acc_next;
    logic            en;

    logic [NA-1:0][PW-1:0] p0;
    logic [NA-1:0][PW-1:0] p1;
    logic [NA-1:0][PW-1:0] p2;
    tbga_pkg::pair_res_t r01;
    tbga_pkg::pair_res_t r02;
    tbga_pkg::pair_res_t r12;

    logic signed [ASW-1:0] sum0 [NA];
    logic signed [ASW-1:0] sum1 [NA];
    logic signed [ASW-1:0] sum2 [NA];
    logic [AW-1:0]         clip0 [NA];
    logic [AW-1:0]         clip1 [NA];
    logic [AW-1:0]         clip2 [NA];
    logic                  sat_any;
    logic                  at_limit;

    function automatic logic signed [ASW-1:0] pair_term(tbga_pkg::pair_res_t r, int k);
        logic signed [TW-1:0] mag;
        mag = $signed({1'b0, r.quot[k]});
        if (r.coin)
            return '0;
        else if (r.neg[k])
            return -ASW'(mag);
        else
            return ASW'(mag);
    endfunction

    function automatic logic [AW-1:0] clip(logic signed [ASW-1:0] v);
        priority if (v > tbga_pkg::ACC_MAX)
            return tbga_pkg::ACC_MAX[AW-1:0];
        else if (v < tbga_pkg::ACC_MIN)
            return tbga_pkg::ACC_MIN[AW-1:0];
        else
            return v[AW-1:0];
    endfunction

    function automatic logic over(logic signed [ASW-1:0] v);
        return (v > tbga_pkg::ACC_MAX) || (v < tbga_pkg::ACC_MIN);
    endfunction

    assign en        = !acc_valid_reg || acc_ready;
    assign pos_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mass_reg <= tbga_pkg::MASS_RESET;
        else if (cfg_we)
            mass_reg <= cfg_wdata[MSW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            acc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[PL-2:0], pos_valid};
            acc_valid_reg <= vld_reg[PL-1];
        end
    end

    assign p0 = {pos.pos0_z, pos.pos0_y, pos.pos0_x};
    assign p1 = {pos.pos1_z, pos.pos1_y, pos.pos1_x};
    assign p2 = {pos.pos2_z, pos.pos2_y, pos.pos2_x};

    tbga_pair u_pair01 (
        .clk (clk), .en (en), .pos_a (p0), .pos_b (p1), .mass (mass_reg), .res (r01)
    );

    tbga_pair u_pair02 (
        .clk (clk), .en (en), .pos_a (p0), .pos_b (p2), .mass (mass_reg), .res (r02)
    );

    tbga_pair u_pair12 (
        .clk (clk), .en (en), .pos_a (p1), .pos_b (p2), .mass (mass_reg), .res (r12)
    );

    // body i loses the pair term, body j gains it
    always_comb
    begin
        sat_any = 1'b0;
        for (int k = 0; k < NA; k++)
        begin
            sum0[k]  = -pair_term(r01, k) - pair_term(r02, k);
            sum1[k]  = pair_term(r01, k) - pair_term(r12, k);
            sum2[k]  = pair_term(r02, k) + pair_term(r12, k);
            clip0[k] = clip(sum0[k]);
            clip1[k] = clip(sum1[k]);
            clip2[k] = clip(sum2[k]);
            sat_any  = sat_any || over(sum0[k]) || over(sum1[k]) || over(sum2[k]);
        end
        acc_next.acc0_x          = clip0[0];
        acc_next.acc0_y          = clip0[1];
        acc_next.acc0_z          = clip0[2];
        acc_next.acc1_x          = clip1[0];
        acc_next.acc1_y          = clip1[1];
        acc_next.acc1_z          = clip1[2];
        acc_next.acc2_x          = clip2[0];
        acc_next.acc2_y          = clip2[1];
        acc_next.acc2_z          = clip2[2];
        acc_next.coincident_pair = r01.coin || r02.coin || r12.coin;
        acc_next.accel_saturated = sat_any;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= acc_next;
    end

    assign acc_valid = acc_valid_reg;
    assign acc       = acc_reg;

    // some output word sits at a rail whenever the clip flag is up
    assign at_limit =
        (acc_reg.acc0_x == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc0_x == tbga_pkg::ACC_MIN[AW-1:0]) ||
        (acc_reg.acc0_y == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc0_y == tbga_pkg::ACC_MIN[AW-1:0]) ||
        (acc_reg.acc0_z == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc0_z == tbga_pkg::ACC_MIN[AW-1:0]) ||
        (acc_reg.acc1_x == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc1_x == tbga_pkg::ACC_MIN[AW-1:0]) ||
        (acc_reg.acc1_y == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc1_y == tbga_pkg::ACC_MIN[AW-1:0]) ||
        (acc_reg.acc1_z == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc1_z == tbga_pkg::ACC_MIN[AW-1:0]) ||
        (acc_reg.acc2_x == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc2_x == tbga_pkg::ACC_MIN[AW-1:0]) ||
        (acc_reg.acc2_y == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc2_y == tbga_pkg::ACC_MIN[AW-1:0]) ||
        (acc_reg.acc2_z == tbga_pkg::ACC_MAX[AW-1:0]) ||
        (acc_reg.acc2_z == tbga_pkg::ACC_MIN[AW-1:0]);

    `TBGA_ASSERT_NEXT(a_enter, pos_valid && pos_ready, vld_reg[0])
    `TBGA_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_reg))
    `TBGA_ASSERT_NEXT(a_drain, en && vld_reg[PL-1], acc_valid)
    `TBGA_ASSERT_NOW(a_sat_rail, acc_valid && acc.accel_saturated, at_limit)

endmodule

`default_nettype wire

### hw/rtl/tbga_isqrt.sv
// ----------------------------------------------------------------------------
// tbga_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module tbga_isqrt (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [tbga_pkg::SUM_W-1:0]   radicand,
    output logic      [tbga_pkg::ROOT_W-1:0]  root
);

    localparam int SW = tbga_pkg::SUM_W;
    localparam int RW = tbga_pkg::ROOT_W;
    localparam int TW = tbga_pkg::TRIAL_W;
    localparam int NS = tbga_pkg::SQRT_STAGES;

    logic [SW-1:0] rem_reg  [NS];
    logic [RW-1:0] root_reg [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            localparam int B = NS - 1 - s;
            logic [SW-1:0] rem_in;
            logic [SW-1:0] rem_next;
            logic [RW-1:0] root_in;
            logic [RW-1:0] root_next;
            logic [TW-1:0] trial;

            if (s == 0)
            begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
            end

            // (r + 2^b)^2 - r^2 = 2^(b+1) r + 2^(2b)
            always_comb
            begin
                trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
                if (TW'(rem_in) >= trial)
                begin
                    rem_next  = rem_in - trial[SW-1:0];
                    root_next = root_in | (RW'(1) << B);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[NS-1];

endmodule

`default_nettype wire

### hw/rtl/tbga_div.sv
// ----------------------------------------------------------------------------
// tbga_div
// pipelined restoring divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
`default_nettype none

module tbga_div (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [tbga_pkg::NUM_W-1:0]   num,
    input  wire logic [tbga_pkg::DEN_W-1:0]   den,
    output logic      [tbga_pkg::QUOT_W-1:0]  quot
);

    localparam int NW = tbga_pkg::NUM_W;
    localparam int DW = tbga_pkg::DEN_W;
    localparam int QW = tbga_pkg::QUOT_W;
    localparam int NS = tbga_pkg::DIV_STAGES;

    logic [NW-1:0] n_reg   [NS];
    logic [DW-1:0] den_reg [NS];
    logic [QW-1:0] q_reg   [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            localparam int B = NS - 1 - s;
            logic [NW-1:0] n_in;
            logic [NW-1:0] n_next;
            logic [DW-1:0] den_in;
            logic [QW-1:0] q_in;
            logic [QW-1:0] q_next;
            logic [NW-1:0] den_ext;

            if (s == 0)
            begin : g_first
                assign n_in   = num;
                assign den_in = den;
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign n_in   = n_reg[s-1];
                assign den_in = den_reg[s-1];
                assign q_in   = q_reg[s-1];
            end

            // a quotient too big for the field leaves every bit set
            always_comb
            begin
                den_ext = NW'(den_in);
                if ((n_in >> B) >= den_ext)
                begin
                    n_next = n_in - (den_ext << B);
                    q_next = q_in | (QW'(1) << B);
                end
                else
                begin
                    n_next = n_in;
                    q_next = q_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[s]   <= n_next;
                    den_reg[s] <= den_in;
                    q_reg[s]   <= q_next;
                end
            end
        end
    endgenerate

    assign quot = q_reg[NS-1];

endmodule

`default_nettype wire

### hw/rtl/tbga_pair.sv
// ----------------------------------------------------------------------------
// tbga_pair
// one body pair: difference, distance cubed and the three scaled quotients
// ----------------------------------------------------------------------------
`default_nettype none

module tbga_pair (
    input  wire logic                                              clk,
    input  wire logic                                              en,
    input  wire logic [tbga_pkg::NUM_AXES-1:0][tbga_pkg::POS_W-1:0] pos_a,
    input  wire logic [tbga_pkg::NUM_AXES-1:0][tbga_pkg::POS_W-1:0] pos_b,
    input  wire logic [tbga_pkg::MASS_W-1:0]                        mass,
    output tbga_pkg::pair_res_t                                     res
);

    localparam int NA  = tbga_pkg::NUM_AXES;
    localparam int PW  = tbga_pkg::POS_W;
    localparam int DFW = tbga_pkg::DIFF_W;
    localparam int MW  = tbga_pkg::MAG_W;
    localparam int SQW = tbga_pkg::SQ_W;
    localparam int SW  = tbga_pkg::SUM_W;
    localparam int RW  = tbga_pkg::ROOT_W;
    localparam int SPW = tbga_pkg::SPLIT_W;
    localparam int PTW = tbga_pkg::PART_W;
    localparam int DW  = tbga_pkg::DEN_W;
    localparam int PRW = tbga_pkg::PROD_W;
    localparam int FS  = tbga_pkg::FRAC_SHIFT;
    localparam int QW  = tbga_pkg::QUOT_W;
    localparam int SD  = tbga_pkg::SQRT_STAGES;
    localparam int PD  = tbga_pkg::PROD_DLY;
    localparam int FD  = tbga_pkg::FLAG_DLY;
    localparam int FW  = NA + 1;

    logic [NA-1:0][DFW-1:0] diff;
    logic [NA-1:0][DFW-1:0] mag_full;

    logic [NA-1:0][MW-1:0]  mag1_reg;
    logic [NA-1:0]          neg1_reg;
    logic [NA-1:0][SQW-1:0] sq2_reg;
    logic [NA-1:0][PRW-1:0] prod2_reg;
    logic [NA-1:0]          neg2_reg;
    logic [SW-1:0]          sum3_reg;
    logic [FW-1:0]          flag3_reg;

    logic [RW-1:0]          root;
    logic [SW-1:0]          sum_line_reg  [SD];
    logic [NA-1:0][PRW-1:0] prod_line_reg [PD];
    logic [FW-1:0]          flag_line_reg [FD];

    logic [PTW-1:0]         plo_reg;
    logic [PTW-1:0]         phi_reg;
    logic [DW-1:0]          den_reg;
    logic [NA-1:0][QW-1:0]  quot;

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            diff[k]     = {pos_a[k][PW-1], pos_a[k]} - {pos_b[k][PW-1], pos_b[k]};
            mag_full[k] = diff[k][DFW-1] ? (~diff[k] + DFW'(1)) : diff[k];
        end
    end

    // front end: difference, squares and mass scaling, distance squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NA; k++)
            begin
                mag1_reg[k]  <= mag_full[k][MW-1:0];
                neg1_reg[k]  <= diff[k][DFW-1];
                sq2_reg[k]   <= SQW'(mag1_reg[k]) * SQW'(mag1_reg[k]);
                prod2_reg[k] <= PRW'(mass) * PRW'(mag1_reg[k]);
            end
            neg2_reg  <= neg1_reg;
            sum3_reg  <= SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2]);
            flag3_reg <= {(sq2_reg[0] == '0) && (sq2_reg[1] == '0) && (sq2_reg[2] == '0),
                          neg2_reg};
        end
    end

    tbga_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum3_reg),
        .root     (root)
    );

    // side data rides along with the long units
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_line_reg[0]  <= sum3_reg;
            prod_line_reg[0] <= prod2_reg;
            flag_line_reg[0] <= flag3_reg;
            for (int i = 1; i < SD; i++)
                sum_line_reg[i] <= sum_line_reg[i-1];
            for (int i = 1; i < PD; i++)
                prod_line_reg[i] <= prod_line_reg[i-1];
            for (int i = 1; i < FD; i++)
                flag_line_reg[i] <= flag_line_reg[i-1];
        end
    end

    // distance cubed as two half-width partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= PTW'(sum_line_reg[SD-1][SPW-1:0]) * PTW'(root);
            phi_reg <= PTW'(sum_line_reg[SD-1][SW-1:SPW]) * PTW'(root);
            den_reg <= (DW'(phi_reg) << SPW) + DW'(plo_reg);
        end
    end

    genvar k;
    generate
        for (k = 0; k < NA; k++)
        begin : g_axis
            tbga_div u_div (
                .clk  (clk),
                .en   (en),
                .num  ({prod_line_reg[PD-1][k], {FS{1'b0}}}),
                .den  (den_reg),
                .quot (quot[k])
            );
        end
    endgenerate

    assign res.quot = quot;
    assign res.neg  = flag_line_reg[FD-1][NA-1:0];
    assign res.coin = flag_line_reg[FD-1][NA];

endmodule

`default_nettype wire

### sim/tb_three_body_gravity_accel.sv
// ----------------------------------------------------------------------------
// tb_three_body_gravity_accel
// self-checking bench for the three-body gravity acceleration block
//
// Position words are pulled from a queue by a clocked driver that inserts
// random gaps. A monitor with random stalls on the result side checks every
// result word, field by field, against a bit-exact fixed-point predictor.
// The mass register is rewritten between phases, only while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_three_body_gravity_accel;

    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [127:0] QUOT_MAX = (128'd1 << tbga_pkg::QUOT_W) - 1;

    logic                        clk;
    logic                        rst_n;
    logic                        pos_valid;
    logic                        pos_ready;
    tbga_pkg::pos_word_t         pos;
    logic                        acc_valid;
    logic                        acc_ready;
    tbga_pkg::acc_word_t         acc;
    logic                        cfg_we;
    logic [tbga_pkg::CFG_W-1:0]  cfg_wdata;

    tbga_pkg::pos_word_t         pend_pos[$];
    tbga_pkg::acc_word_t         exp_acc[$];
    logic [tbga_pkg::MASS_W-1:0] mass_now;
    bit                          no_idle;
    int                          mismatches;
    int                          words_in;
    int                          words_out;
    int                          coin_seen;
    int                          sat_seen;
    int                          quiet_cycles;

    three_body_gravity_accel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos_valid (pos_valid),
        .pos_ready (pos_ready),
        .pos       (pos),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [127:0] root_floor(logic [127:0] s);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = tbga_pkg::ROOT_W; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= s)
                r = c;
        end
        return r;
    endfunction

    // exact pairwise sum, each term a saturated truncating quotient
    function automatic tbga_pkg::acc_word_t predict_accel(
        tbga_pkg::pos_word_t w, logic [tbga_pkg::MASS_W-1:0] m);
        longint              p[3][3];
        longint              a[3][3];
        longint              d[3];
        logic [127:0]        mag[3];
        logic [127:0]        s;
        logic [127:0]        den;
        logic [127:0]        q;
        longint              t;
        bit                  coin;
        bit                  sat;
        int                  pi[3];
        int                  pj[3];
        tbga_pkg::acc_word_t res;
        pi = '{0, 0, 1};
        pj = '{1, 2, 2};
        p[0] = '{longint'(w.pos0_x), longint'(w.pos0_y), longint'(w.pos0_z)};
        p[1] = '{longint'(w.pos1_x), longint'(w.pos1_y), longint'(w.pos1_z)};
        p[2] = '{longint'(w.pos2_x), longint'(w.pos2_y), longint'(w.pos2_z)};
        coin = 1'b0;
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                a[i][k] = 0;
        for (int n = 0; n < 3; n++)
        begin
            s = '0;
            for (int k = 0; k < 3; k++)
            begin
                d[k] = p[pi[n]][k] - p[pj[n]][k];
                mag[k] = 128'(d[k] < 0 ? -d[k] : d[k]);
                s = s + mag[k] * mag[k];
            end
            if (s == 0)
                coin = 1'b1;
            else
            begin
                den = s * root_floor(s);
                for (int k = 0; k < 3; k++)
                begin
                    q = ((128'(m) * mag[k]) << tbga_pkg::FRAC_SHIFT) / den;
                    if (q > QUOT_MAX)
                        q = QUOT_MAX;
                    t = longint'(q);
                    if (d[k] < 0)
                        t = -t;
                    a[pi[n]][k] -= t;
                    a[pj[n]][k] += t;
                end
            end
        end
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
            begin
                if (a[i][k] > 64'sd2147483647)
                begin
                    a[i][k] = 64'sd2147483647;
                    sat = 1'b1;
                end
                else if (a[i][k] < -64'sd2147483648)
                begin
                    a[i][k] = -64'sd2147483648;
                    sat = 1'b1;
                end
            end
        res = {a[0][0][31:0], a[0][1][31:0], a[0][2][31:0],
               a[1][0][31:0], a[1][1][31:0], a[1][2][31:0],
               a[2][0][31:0], a[2][1][31:0], a[2][2][31:0], coin, sat};
        return res;
    endfunction

    // driver: one pending word at a time, random gap after each unless no_idle is set
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid <= 1'b0;
            pos <= '0;
            gap_left = 0;
        end
        else
        begin
            if (pos_valid && pos_ready)
            begin
                exp_acc.push_back(predict_accel(pos, mass_now));
                words_in++;
            end
            if (!(pos_valid && !pos_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pos_valid <= 1'b0;
                end
                else if (pend_pos.size() > 0)
                begin
                    pos <= pend_pos.pop_front();
                    pos_valid <= 1'b1;
                    gap_left = no_idle ? 0 : $urandom_range(0, 4);
                end
                else
                    pos_valid <= 1'b0;
            end
        end
    end

    // monitor: random stall per result word unless no_idle is set
    int stall_left;
    string fname[9] = '{"acc0_x", "acc0_y", "acc0_z", "acc1_x", "acc1_y", "acc1_z",
                        "acc2_x", "acc2_y", "acc2_z"};
    always @(posedge clk or negedge rst_n)
    begin
        tbga_pkg::acc_word_t want;
        logic [31:0] ew;
        logic [31:0] aw;
        bit bad;
        if (!rst_n)
        begin
            acc_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (acc_valid && acc_ready)
            begin
                words_out++;
                if (exp_acc.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", acc);
                end
                else
                begin
                    want = exp_acc.pop_front();
                    bad = 1'b0;
                    for (int f = 0; f < 9; f++)
                    begin
                        ew = want[289 - 32*f -: 32];
                        aw = acc[289 - 32*f -: 32];
                        if (ew !== aw)
                        begin
                            bad = 1'b1;
                            if (mismatches < 10)
                                $display("word %0d %s: expected %h got %h",
                                         words_out, fname[f], ew, aw);
                        end
                    end
                    if (want.coincident_pair !== acc.coincident_pair ||
                        want.accel_saturated !== acc.accel_saturated)
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("word %0d flags: expected coin %b sat %b got %b %b",
                                     words_out, want.coincident_pair, want.accel_saturated,
                                     acc.coincident_pair, acc.accel_saturated);
                    end
                    if (bad)
                        mismatches++;
                    coin_seen += want.coincident_pair;
                    sat_seen += want.accel_saturated;
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                acc_ready <= 1'b0;
            end
            else
                acc_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((pos_valid && pos_ready) || (acc_valid && acc_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic tbga_pkg::pos_word_t pack_pos(logic [31:0] v[9]);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    endfunction

    // mostly clustered bodies so terms are large, some full-range noise
    function automatic tbga_pkg::pos_word_t random_pos();
        logic [31:0] v[9];
        logic [31:0] base[3];
        int shape;
        int span;
        shape = $urandom_range(0, 9);
        span = $urandom_range(0, 28);
        for (int k = 0; k < 3; k++)
            base[k] = $urandom;
        for (int i = 0; i < 9; i++)
        begin
            if (shape < 3)
                v[i] = $urandom;
            else
                v[i] = base[i % 3] + (($urandom >> (31 - span)) - (32'd1 << span));
        end
        if (shape == 9)
        begin
            // two bodies on one spot
            for (int k = 0; k < 3; k++)
                v[3 + k] = v[k];
        end
        else if (shape == 8)
            v[7] = v[1];
        return pack_pos(v);
    endfunction

    task automatic drain_pipe();
        while (pend_pos.size() > 0 || pos_valid || exp_acc.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mass(logic [tbga_pkg::CFG_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mass_now = v[tbga_pkg::MASS_W-1:0];
    endtask

    task automatic queue_random(int n);
        repeat (n) pend_pos.push_back(random_pos());
    endtask

    task automatic queue_directed();
        logic [31:0] v[9];
        v = '{default: 32'h0};
        pend_pos.push_back(pack_pos(v));
        v = '{default: 32'h7fffffff};
        pend_pos.push_back(pack_pos(v));
        v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h0, 32'h0, 32'h0};
        pend_pos.push_back(pack_pos(v));
        v = '{32'h80000000, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0,
              32'h0, 32'h80000000, 32'h7fffffff};
        pend_pos.push_back(pack_pos(v));
        // adjacent on one axis, third body far away
        v = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h40000000, 32'h0, 32'h0};
        pend_pos.push_back(pack_pos(v));
        v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 32'h0};
        pend_pos.push_back(pack_pos(v));
        // pair (0,2) coincident, then pair (1,2) coincident, unit-ish separations
        v = '{32'h01000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
              32'h01000000, 32'h0, 32'h0};
        pend_pos.push_back(pack_pos(v));
        v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h01000000, 32'h0,
              32'h0, 32'h01000000, 32'h0};
        pend_pos.push_back(pack_pos(v));
        v = '{32'h01000000, 32'h0, 32'h0, 32'hff000000, 32'h0, 32'h0,
              32'h0, 32'h01000000, 32'h0};
        pend_pos.push_back(pack_pos(v));
        v = '{32'h00400000, 32'hffc00000, 32'h00800000, 32'hff800000, 32'h00400000,
              32'h0, 32'h0, 32'h0, 32'hff000000};
        pend_pos.push_back(pack_pos(v));
        v = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h0,
              32'h1, 32'h1, 32'h1};
        pend_pos.push_back(pack_pos(v));
        v = '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
              32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa};
        pend_pos.push_back(pack_pos(v));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mass_now = tbga_pkg::MASS_RESET;
        no_idle = 1'b0;
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        coin_seen = 0;
        sat_seen = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset mass value
        queue_directed();
        queue_random(140);
        drain_pipe();

        // top bit of the write is dropped, leaving the largest mass
        write_mass(32'hffffffff);
        queue_directed();
        queue_random(90);
        drain_pipe();

        write_mass(32'h0);
        no_idle = 1'b1;
        queue_directed();
        queue_random(50);
        drain_pipe();

        write_mass(32'h1);
        no_idle = 1'b0;
        queue_random(100);
        drain_pipe();

        write_mass($urandom);
        queue_random(100);
        drain_pipe();

        write_mass(32'h80010000);
        no_idle = 1'b1;
        queue_random(60);
        drain_pipe();

        $display("%0d position words in, %0d results out over six mass settings",
                 words_in, words_out);
        $display("%0d results flagged coincident, %0d saturated", coin_seen, sat_seen);
        if (mismatches == 0 && exp_acc.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
